@@ src/idal_pkg.sv @@
// idal_pkg: shared types and codes of the ID allocator
// command codes, controller states, result item struct
// no dependencies
package idal_pkg;

  // fixed field widths
  localparam int CMD_W  = 3;
  localparam int ID_W   = 32;
  localparam int CNT_W  = 11;
  localparam int WORD_W = 64;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WORD_W-1:0] word_t;

  // command codes carried by in_command
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_RESERVE = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_REINIT  = 3'd4
  } cmd_t;

  // configuration register indexes
  localparam logic CFG_BASE_ID  = 1'b0;
  localparam logic CFG_ID_COUNT = 1'b1;

  // register reset values and special results
  localparam id_t  BASE_RESET  = 32'd0;
  localparam cnt_t COUNT_RESET = 11'd1024;
  localparam id_t  ID_NONE     = 32'hFFFF_FFFF;

  // controller states
  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_t;

  // one result item
  typedef struct packed {
    id_t  granted_id;
    logic success;
    cnt_t in_use_count;
  } result_t;

endpackage

@@ src/idal_ram.sv @@
// idal_ram: simple dual port synchronous ram, one write and one read port
// read data registered; no package dependency
module idal_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/idal_ctrl.sv @@
// idal_ctrl: sequencer of the ID allocator, read-modify-write of the link
// memory and bitmap, list walk for reserve, rebuild sweep; uses idal_pkg
module idal_ctrl #(
  parameter int POOL_SIZE = 1024,
  parameter int IW        = 11,
  parameter int AW        = 10,
  parameter int WORDS     = 16,
  parameter int WAW       = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  idal_pkg::id_t            base_id,
  input  idal_pkg::cnt_t           id_count,
  input  logic                     in_valid,
  input  logic [idal_pkg::CMD_W-1:0] in_command,
  input  idal_pkg::id_t            in_id_value,
  input  logic                     res_busy,
  output logic                     ready,
  output logic                     link_we,
  output logic [AW-1:0]            link_waddr,
  output logic [IW-1:0]            link_wdata,
  output logic                     link_re,
  output logic [AW-1:0]            link_raddr,
  input  logic [IW-1:0]            link_rdata,
  output logic                     bm_we,
  output logic [WAW-1:0]           bm_waddr,
  output idal_pkg::word_t          bm_wdata,
  output logic                     bm_re,
  output logic [WAW-1:0]           bm_raddr,
  input  idal_pkg::word_t          bm_rdata,
  output logic                     fin_valid,
  output idal_pkg::result_t        fin
);

  localparam int CW  = (IW > idal_pkg::CNT_W) ? IW : idal_pkg::CNT_W;
  localparam int IXW = (IW > 6) ? IW : 7;
  localparam logic [IW-1:0] NULL_IDX = IW'(POOL_SIZE);

  // id_count as the pool size: zero taken as one, capped at the pool
  function automatic logic [IW-1:0] clamp_count(idal_pkg::cnt_t c);
    logic [CW-1:0] n;
    n = CW'(c);
    if (n == '0) n = CW'(1);
    if (n > CW'(POOL_SIZE)) n = CW'(POOL_SIZE);
    return IW'(n);
  endfunction

  // bitmap word holding an index
  function automatic logic [WAW-1:0] word_of(logic [IW-1:0] i);
    logic [IXW-1:0] t;
    t = IXW'(i);
    return WAW'(t >> 6);
  endfunction

  // single bit mask of an index inside its word
  function automatic idal_pkg::word_t mask_of(logic [IW-1:0] i);
    logic [IXW-1:0] t;
    t = IXW'(i);
    return idal_pkg::word_t'(1) << t[5:0];
  endfunction

  idal_pkg::state_t state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] total_r, total_nxt;
  logic [IW-1:0] live_r, live_nxt;
  logic [IW-1:0] sw_r, sw_nxt;
  logic          reinit_r, reinit_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] prev_r, prev_nxt;
  logic          prev_null_r, prev_null_nxt;
  logic [idal_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  idal_pkg::id_t id_r, id_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          inrange_r, inrange_nxt;
  idal_pkg::word_t bmw_r, bmw_nxt;

  logic          accept;
  idal_pkg::id_t diff;
  logic          in_range;
  logic          cur_bit;
  logic [IW-1:0] sw_inc;

  // range check of the incoming id against the live pool
  assign diff     = in_id_value - base_id;
  assign in_range = (in_id_value >= base_id) && (diff < idal_pkg::id_t'(live_r));

  assign ready  = (state_r == idal_pkg::S_IDLE) && !res_busy;
  assign accept = in_valid && ready;

  assign cur_bit = |(bm_rdata & mask_of(idx_r));
  assign sw_inc  = sw_r + IW'(1);

  // next state, memory ports and result
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    total_nxt     = total_r;
    live_nxt      = live_r;
    sw_nxt        = sw_r;
    reinit_nxt    = reinit_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    prev_null_nxt = prev_null_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    idx_nxt       = idx_r;
    inrange_nxt   = inrange_r;
    bmw_nxt       = bmw_r;
    link_we       = 1'b0;
    link_waddr    = AW'(idx_r);
    link_wdata    = head_r;
    link_re       = 1'b0;
    link_raddr    = AW'(head_r);
    bm_we         = 1'b0;
    bm_waddr      = word_of(idx_r);
    bm_wdata      = bm_rdata & ~mask_of(idx_r);
    bm_re         = 1'b0;
    bm_raddr      = word_of(idx_r);
    fin_valid     = 1'b0;
    fin.granted_id = id_r;
    fin.success    = 1'b0;

    case (state_r)
      // rebuild sweep: ascending chain, bitmap words cleared
      idal_pkg::S_INIT: begin
        link_we    = 1'b1;
        link_waddr = AW'(sw_r);
        link_wdata = (sw_inc < live_r) ? sw_inc : NULL_IDX;
        bm_we      = (sw_r < IW'(WORDS));
        bm_waddr   = WAW'(sw_r);
        bm_wdata   = '0;
        sw_nxt     = sw_inc;
        if (sw_inc == live_r) begin
          state_nxt      = idal_pkg::S_IDLE;
          reinit_nxt     = 1'b0;
          fin_valid      = reinit_r;
          fin.granted_id = id_r;
          fin.success    = 1'b1;
        end
      end

      // take an item and launch the reads, or start the rebuild sweep
      idal_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_command;
          id_nxt      = in_id_value;
          inrange_nxt = in_range;
          idx_nxt     = in_range ? IW'(diff) : NULL_IDX;
          bm_re       = 1'b1;
          bm_raddr    = word_of(in_range ? IW'(diff) : NULL_IDX);
          state_nxt   = idal_pkg::S_EXEC;
          case (in_command)
            idal_pkg::CMD_ALLOC: begin
              link_re    = 1'b1;
              link_raddr = AW'(head_r);
              bm_raddr   = word_of(head_r);
            end
            idal_pkg::CMD_REINIT: begin
              bm_re      = 1'b0;
              live_nxt   = clamp_count(id_count);
              sw_nxt     = '0;
              head_nxt   = '0;
              total_nxt  = '0;
              reinit_nxt = 1'b1;
              state_nxt  = idal_pkg::S_INIT;
            end
            default: begin
            end
          endcase
        end
      end

      // modify and write back
      idal_pkg::S_EXEC: begin
        state_nxt = idal_pkg::S_IDLE;
        fin_valid = 1'b1;
        case (cmd_r)
          idal_pkg::CMD_ALLOC: begin
            if (head_r < live_r) begin
              head_nxt       = link_rdata;
              bm_we          = 1'b1;
              bm_waddr       = word_of(head_r);
              bm_wdata       = bm_rdata | mask_of(head_r);
              total_nxt      = total_r + IW'(1);
              fin.granted_id = base_id + idal_pkg::id_t'(head_r);
              fin.success    = 1'b1;
            end else begin
              fin.granted_id = idal_pkg::ID_NONE;
            end
          end
          idal_pkg::CMD_RELEASE: begin
            if (inrange_r && cur_bit) begin
              bm_we       = 1'b1;
              link_we     = 1'b1;
              head_nxt    = idx_r;
              total_nxt   = (total_r != '0) ? total_r - IW'(1) : total_r;
              fin.success = 1'b1;
            end
          end
          idal_pkg::CMD_QUERY: begin
            fin.success = inrange_r && cur_bit;
          end
          idal_pkg::CMD_RESERVE: begin
            // a free in-range id is on the list: walk from the head
            if (inrange_r && !cur_bit && (head_r < live_r)) begin
              fin_valid     = 1'b0;
              bmw_nxt       = bm_rdata;
              link_re       = 1'b1;
              link_raddr    = AW'(head_r);
              cur_nxt       = head_r;
              prev_null_nxt = 1'b1;
              state_nxt     = idal_pkg::S_WALK;
            end
          end
          default: begin
          end
        endcase
      end

      // one list node per cycle; link_rdata is the successor of cur
      idal_pkg::S_WALK: begin
        if (cur_r == idx_r) begin
          if (prev_null_r) begin
            head_nxt = link_rdata;
          end else begin
            link_we    = 1'b1;
            link_waddr = AW'(prev_r);
            link_wdata = link_rdata;
          end
          bm_we       = 1'b1;
          bm_wdata    = bmw_r | mask_of(idx_r);
          total_nxt   = total_r + IW'(1);
          fin_valid   = 1'b1;
          fin.success = 1'b1;
          state_nxt   = idal_pkg::S_IDLE;
        end else if (link_rdata >= live_r) begin
          fin_valid = 1'b1;
          state_nxt = idal_pkg::S_IDLE;
        end else begin
          prev_nxt      = cur_r;
          prev_null_nxt = 1'b0;
          cur_nxt       = link_rdata;
          link_re       = 1'b1;
          link_raddr    = AW'(link_rdata);
        end
      end

      default: begin
        state_nxt = idal_pkg::S_IDLE;
      end
    endcase

    fin.in_use_count = idal_pkg::cnt_t'(total_nxt);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= idal_pkg::S_INIT;
      head_r   <= '0;
      total_r  <= '0;
      live_r   <= clamp_count(idal_pkg::COUNT_RESET);
      sw_r     <= '0;
      reinit_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      total_r  <= total_nxt;
      live_r   <= live_nxt;
      sw_r     <= sw_nxt;
      reinit_r <= reinit_nxt;
    end
  end

  // item payload and walk registers
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    prev_null_r <= prev_null_nxt;
    cmd_r       <= cmd_nxt;
    id_r        <= id_nxt;
    idx_r       <= idx_nxt;
    inrange_r   <= inrange_nxt;
    bmw_r       <= bmw_nxt;
  end

  // a successful allocate adds exactly one to the count
  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == idal_pkg::S_EXEC && cmd_r == idal_pkg::CMD_ALLOC && head_r < live_r)
    |=> (total_r == $past(total_r) + IW'(1)))
    else $error("allocate did not bump the in-use count");

  // never more ids in use than the pool holds
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == idal_pkg::S_IDLE) |-> (total_r <= live_r))
    else $error("in-use count above pool size");

  // the first walk step always starts at the list head
  a_walk_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == idal_pkg::S_WALK && prev_null_r) |-> (cur_r == head_r))
    else $error("walk lost the list head");

endmodule

@@ src/id_allocator_free_list_core.sv @@
// id_allocator_free_list_core: top level of the free list ID allocator
// config registers, output register with skid entry; uses idal_pkg,
// idal_ram and idal_ctrl
//
// Usage: items come in on in_valid/in_stall with in_command and
// in_id_value; one result item per input item leaves on out_valid/out_stall.
// base_id and id_count are to be written on cfg_we/cfg_index/cfg_data only
// while idle, which the block itself does not enforce; id_count takes effect
// at a reinitialize command; reset restores both to their defaults.
// Allocate, release, query and unknown codes: accept with memory read, then
// modify and write back. Reserve of a free ID then walks the list from the
// head, one link memory read per node ahead of it; a reserve of an
// out-of-range or allocated ID ends after the write back step. Reinitialize
// runs the rebuild sweep over n link memory entries, n the clamped id_count.
// Each result is registered into the output register or the skid entry.
// Reset: synchronous, active low; the same sweep then runs over the link
// memory (1024 entries by default) and no item is taken during it.
// Stall: a finished result waits in the output register while the next item
// is taken; a second result parks in the skid entry and input stalls until
// the receiver drains it.
module id_allocator_free_list_core #(
  parameter int POOL_SIZE = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  idal_pkg::id_t              cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [idal_pkg::CMD_W-1:0] in_command,
  input  idal_pkg::id_t              in_id_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output idal_pkg::id_t              out_granted_id,
  output logic                       out_success,
  output idal_pkg::cnt_t             out_in_use_count
);

  localparam int IW    = $clog2(POOL_SIZE + 1);
  localparam int AW    = $clog2(POOL_SIZE);
  localparam int WORDS = (POOL_SIZE + 63) / 64;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

  idal_pkg::id_t  base_id_r;
  idal_pkg::cnt_t id_count_r;

  logic                ready;
  logic                link_we, link_re;
  logic [AW-1:0]       link_waddr, link_raddr;
  logic [IW-1:0]       link_wdata, link_rdata;
  logic                bm_we, bm_re;
  logic [WAW-1:0]      bm_waddr, bm_raddr;
  idal_pkg::word_t     bm_wdata, bm_rdata;
  logic                fin_valid;
  idal_pkg::result_t   fin;

  logic                out_valid_r;
  idal_pkg::result_t   out_r;
  logic                res_valid_r;
  idal_pkg::result_t   res_r;
  logic                out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r  <= idal_pkg::BASE_RESET;
      id_count_r <= idal_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        idal_pkg::CFG_BASE_ID:  base_id_r  <= cfg_data;
        idal_pkg::CFG_ID_COUNT: id_count_r <= idal_pkg::cnt_t'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  idal_ctrl #(
    .POOL_SIZE (POOL_SIZE),
    .IW        (IW),
    .AW        (AW),
    .WORDS     (WORDS),
    .WAW       (WAW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .base_id     (base_id_r),
    .id_count    (id_count_r),
    .in_valid    (in_valid),
    .in_command  (in_command),
    .in_id_value (in_id_value),
    .res_busy    (res_valid_r),
    .ready       (ready),
    .link_we     (link_we),
    .link_waddr  (link_waddr),
    .link_wdata  (link_wdata),
    .link_re     (link_re),
    .link_raddr  (link_raddr),
    .link_rdata  (link_rdata),
    .bm_we       (bm_we),
    .bm_waddr    (bm_waddr),
    .bm_wdata    (bm_wdata),
    .bm_re       (bm_re),
    .bm_raddr    (bm_raddr),
    .bm_rdata    (bm_rdata),
    .fin_valid   (fin_valid),
    .fin         (fin)
  );

  // free list links, null is POOL_SIZE
  idal_ram #(
    .WIDTH (IW),
    .DEPTH (POOL_SIZE),
    .AW    (AW)
  ) u_link_mem (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_en   (link_re),
    .rd_addr (link_raddr),
    .rd_data (link_rdata)
  );

  // allocated bitmap, 64 ids per word
  idal_ram #(
    .WIDTH (idal_pkg::WORD_W),
    .DEPTH (WORDS),
    .AW    (WAW)
  ) u_bitmap_mem (
    .clk     (clk),
    .wr_en   (bm_we),
    .wr_addr (bm_waddr),
    .wr_data (bm_wdata),
    .rd_en   (bm_re),
    .rd_addr (bm_raddr),
    .rd_data (bm_rdata)
  );

  assign in_stall = !ready;
  assign out_free = !out_valid_r || !out_stall;

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= res_valid_r || fin_valid;
        res_valid_r <= 1'b0;
      end else if (fin_valid) begin
        res_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= res_valid_r ? res_r : fin;
    end
    if (fin_valid && !res_valid_r) begin
      res_r <= fin;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_id   = out_r.granted_id;
  assign out_success      = out_r.success;
  assign out_in_use_count = out_r.in_use_count;

  // a result never lands on a full skid entry
  a_skid_free: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid |-> !res_valid_r)
    else $error("result arrived with skid entry full");

  // the skid entry only fills behind a waiting output
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> out_valid_r)
    else $error("skid entry holds an item ahead of the output");

  // no input is taken while a result is parked
  a_park_stall: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> in_stall)
    else $error("input taken with a parked result");

endmodule

@@ tb/sv/tb_id_allocator_free_list_core.sv @@
// tb_id_allocator_free_list_core: self-checking bench of the free list ID allocator
// drives command items, predicts each result item and compares it field by field
// depends on idal_pkg and id_allocator_free_list_core
module tb_id_allocator_free_list_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL = 1024;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [idal_pkg::CMD_W-1:0] cmd;
    idal_pkg::id_t              id;
    bit                         hold;
  } pool_cmd_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = 1'b0;
  idal_pkg::id_t              cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [idal_pkg::CMD_W-1:0] in_command = '0;
  idal_pkg::id_t              in_id_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  idal_pkg::id_t              out_granted_id;
  logic                       out_success;
  idal_pkg::cnt_t             out_in_use_count;

  // item backlog and predicted result items
  pool_cmd_t         cmd_queue[$];
  idal_pkg::result_t predicted_grants[$];

  // shadow of the allocator state and registers
  int unsigned   shadow_link[POOL];
  bit            shadow_taken[POOL];
  int unsigned   shadow_head;
  int unsigned   shadow_total;
  int unsigned   shadow_n;
  idal_pkg::id_t shadow_base;
  int unsigned   shadow_count;

  int idle_pct = 20;
  int stall_pct = 20;
  int send_gap = 0;
  int stall_gap = 0;
  int fail_count = 0;
  int sent_count = 0;
  int recv_count = 0;
  int empty_allocs = 0;
  int reserve_hits = 0;
  int cycle_count = 0;
  int settings_seen = 0;

  id_allocator_free_list_core #(.POOL_SIZE(POOL)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_id_value      (in_id_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_id   (out_granted_id),
    .out_success      (out_success),
    .out_in_use_count (out_in_use_count)
  );

  always #4 clk = ~clk;

  // rebuild the ascending free list from the latched count
  function automatic void rebuild_pool();
    int unsigned n;
    n = shadow_count;
    if (n == 0) n = 1;
    if (n > POOL) n = POOL;
    shadow_n = n;
    for (int i = 0; i < POOL; i++) begin
      shadow_link[i] = (i + 1 < n) ? i + 1 : POOL;
      shadow_taken[i] = 1'b0;
    end
    shadow_head = 0;
    shadow_total = 0;
  endfunction

  // pool index of an id, POOL when out of range (no wrap)
  function automatic int unsigned pool_slot(input idal_pkg::id_t id);
    if (id < shadow_base) return POOL;
    if (id - shadow_base >= shadow_n) return POOL;
    return id - shadow_base;
  endfunction

  // apply one command item to the shadow state and give its result item
  function automatic idal_pkg::result_t predict_grant(input logic [idal_pkg::CMD_W-1:0] cmd,
                                                      input idal_pkg::id_t id);
    idal_pkg::result_t r;
    int unsigned       slot;
    int unsigned       prev;
    int unsigned       cur;
    int unsigned       steps;
    r.granted_id = id;
    r.success = 1'b0;
    case (cmd)
      idal_pkg::CMD_ALLOC: begin
        if (shadow_head < shadow_n) begin
          slot = shadow_head;
          shadow_head = shadow_link[slot];
          shadow_taken[slot] = 1'b1;
          shadow_total++;
          r.granted_id = shadow_base + idal_pkg::id_t'(slot);
          r.success = 1'b1;
        end else begin
          r.granted_id = idal_pkg::ID_NONE;
          empty_allocs++;
        end
      end
      idal_pkg::CMD_RELEASE: begin
        slot = pool_slot(id);
        if (slot != POOL && shadow_taken[slot]) begin
          shadow_taken[slot] = 1'b0;
          if (shadow_total > 0) shadow_total--;
          shadow_link[slot] = shadow_head;
          shadow_head = slot;
          r.success = 1'b1;
        end
      end
      idal_pkg::CMD_RESERVE: begin
        slot = pool_slot(id);
        if (slot != POOL && !shadow_taken[slot]) begin
          prev = POOL;
          cur = shadow_head;
          steps = 0;
          // bounded walk down the free list looking for the slot
          while (cur < shadow_n && steps < POOL) begin
            if (cur == slot) begin
              if (prev == POOL) shadow_head = shadow_link[cur];
              else shadow_link[prev] = shadow_link[cur];
              shadow_taken[slot] = 1'b1;
              shadow_total++;
              r.success = 1'b1;
              reserve_hits++;
              break;
            end
            prev = cur;
            cur = shadow_link[cur];
            steps++;
          end
        end
      end
      idal_pkg::CMD_QUERY: begin
        slot = pool_slot(id);
        if (slot != POOL && shadow_taken[slot]) r.success = 1'b1;
      end
      idal_pkg::CMD_REINIT: begin
        rebuild_pool();
        r.success = 1'b1;
      end
      default: ;
    endcase
    r.in_use_count = idal_pkg::cnt_t'(shadow_total);
    return r;
  endfunction

  // driver: present queued items, random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_grants = {predicted_grants, predict_grant(in_command, in_id_value)};
        sent_count++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (cmd_queue.size() == 0 ||
                     (cmd_queue[0].hold && predicted_grants.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
          in_valid <= 1'b0;
          send_gap = $urandom_range(0, 6);
        end else begin
          in_valid <= 1'b1;
          in_command <= cmd_queue[0].cmd;
          in_id_value <= cmd_queue[0].id;
          void'(cmd_queue.pop_front());
        end
      end
    end
  end

  // monitor: check result items in order, random stall bursts
  always @(posedge clk) begin : result_check
    idal_pkg::result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        recv_count++;
        if (predicted_grants.size() == 0) begin
          $error("result item with none expected: granted_id %h", out_granted_id);
          fail_count++;
        end else begin
          want = predicted_grants.pop_front();
          if (out_granted_id !== want.granted_id) begin
            $error("granted_id: expected %h, got %h", want.granted_id, out_granted_id);
            fail_count++;
          end
          if (out_success !== want.success) begin
            $error("success: expected %b, got %b", want.success, out_success);
            fail_count++;
          end
          if (out_in_use_count !== want.in_use_count) begin
            $error("in_use_count: expected %0d, got %0d", want.in_use_count,
                   out_in_use_count);
            fail_count++;
          end
        end
      end
      if (stall_gap > 0) begin
        out_stall <= 1'b1;
        stall_gap--;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        stall_gap = $urandom_range(0, 6);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_id_allocator_free_list_core failed");
      $finish;
    end
  end

  task automatic push_cmd(input logic [idal_pkg::CMD_W-1:0] cmd, input idal_pkg::id_t id,
                          input bit hold = 1'b0);
    pool_cmd_t c;
    c.cmd = cmd;
    c.id = id;
    c.hold = hold;
    cmd_queue = {cmd_queue, c};
  endtask

  // wait until every item is accepted and every result item is back
  task automatic wait_quiet();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || predicted_grants.size() != 0 || in_valid);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input idal_pkg::id_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == idal_pkg::CFG_BASE_ID) shadow_base = val;
    else shadow_count = val[idal_pkg::CNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random mix: mostly in-range ids, some just outside, some anywhere
  task automatic gen_phase(input int items, input idal_pkg::id_t base, input int unsigned n);
    logic [idal_pkg::CMD_W-1:0] cmd;
    idal_pkg::id_t              id;
    int                         r;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 34) cmd = idal_pkg::CMD_ALLOC;
      else if (r < 56) cmd = idal_pkg::CMD_RELEASE;
      else if (r < 70) cmd = idal_pkg::CMD_RESERVE;
      else if (r < 85) cmd = idal_pkg::CMD_QUERY;
      else if (r < 87) cmd = idal_pkg::CMD_REINIT;
      else cmd = 3'($urandom_range(5, 7));
      r = $urandom_range(0, 99);
      if (r < 80) id = base + idal_pkg::id_t'($urandom_range(0, n - 1));
      else if (r < 88) id = base + idal_pkg::id_t'(n) + idal_pkg::id_t'($urandom_range(0, 3));
      else if (r < 94) id = base - 1 - idal_pkg::id_t'($urandom_range(0, 3));
      else id = $urandom;
      push_cmd(cmd, id, k == items / 2);
    end
  endtask

  // stimulus sequence
  initial begin
    idal_pkg::id_t phase_base[10];
    int unsigned   phase_count[10];
    int unsigned   n;
    shadow_base = idal_pkg::BASE_RESET;
    shadow_count = idal_pkg::COUNT_RESET;
    rebuild_pool();

    phase_base[0] = 32'hFFFF_FFF0; phase_count[0] = 32;
    phase_base[1] = 32'h0000_0000; phase_count[1] = 2047;
    phase_base[2] = 32'h8000_0000; phase_count[2] = 64;
    phase_base[3] = $urandom;      phase_count[3] = 1;
    phase_base[4] = $urandom;      phase_count[4] = 3;
    phase_base[5] = $urandom;      phase_count[5] = 8;
    phase_base[6] = $urandom;      phase_count[6] = 17;
    phase_base[7] = $urandom;      phase_count[7] = 40;
    phase_base[8] = 32'h7FFF_FFF0; phase_count[8] = 1024;
    phase_base[9] = $urandom;      phase_count[9] = $urandom_range(2, 60);

    // directed: default pool, pops, pushes, walks, out of range, unknown codes
    push_cmd(idal_pkg::CMD_ALLOC, 32'h0);
    push_cmd(idal_pkg::CMD_ALLOC, 32'h0);
    push_cmd(idal_pkg::CMD_ALLOC, 32'h0);
    push_cmd(idal_pkg::CMD_QUERY, 32'd1);
    push_cmd(idal_pkg::CMD_QUERY, 32'd5);
    push_cmd(idal_pkg::CMD_RELEASE, 32'd1);
    push_cmd(idal_pkg::CMD_RELEASE, 32'd1);
    push_cmd(idal_pkg::CMD_ALLOC, 32'h0);
    push_cmd(idal_pkg::CMD_RESERVE, 32'd5);
    push_cmd(idal_pkg::CMD_RESERVE, 32'd5);
    push_cmd(idal_pkg::CMD_RESERVE, 32'd1023);
    push_cmd(idal_pkg::CMD_RESERVE, 32'd1024);
    push_cmd(idal_pkg::CMD_QUERY, 32'd1023);
    push_cmd(idal_pkg::CMD_RELEASE, 32'hFFFF_FFFF);
    push_cmd(idal_pkg::CMD_QUERY, 32'hFFFF_FFFF);
    push_cmd(3'd5, 32'hA5A5_5A5A);
    push_cmd(3'd6, 32'h5A5A_A5A5);
    push_cmd(3'd7, 32'hFFFF_0000);
    push_cmd(idal_pkg::CMD_REINIT, 32'h0000_1234);
    push_cmd(idal_pkg::CMD_ALLOC, 32'h0);
    gen_phase(40, idal_pkg::BASE_RESET, POOL);
    settings_seen++;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: count zero clamps to one id near the top of the id space
    wait_quiet();
    write_reg(idal_pkg::CFG_BASE_ID, 32'hFFFF_FFFC);
    write_reg(idal_pkg::CFG_ID_COUNT, 32'd0);
    push_cmd(idal_pkg::CMD_REINIT, 32'h0);
    push_cmd(idal_pkg::CMD_ALLOC, 32'h0);
    push_cmd(idal_pkg::CMD_ALLOC, 32'h0);
    push_cmd(idal_pkg::CMD_RELEASE, 32'hFFFF_FFFD);
    push_cmd(idal_pkg::CMD_RELEASE, 32'hFFFF_FFFC);
    push_cmd(idal_pkg::CMD_RESERVE, 32'hFFFF_FFFC);
    push_cmd(idal_pkg::CMD_QUERY, 32'hFFFF_FFFC);
    push_cmd(idal_pkg::CMD_RELEASE, 32'hFFFF_FFFB);
    settings_seen++;

    // random phases over a range of pool sizes and bases
    for (int p = 0; p < 10; p++) begin
      wait_quiet();
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 12 : 35);
      stall_pct = (p % 4 == 0) ? 0 : ((p % 2 == 1) ? 15 : 40);
      write_reg(idal_pkg::CFG_BASE_ID, phase_base[p]);
      write_reg(idal_pkg::CFG_ID_COUNT, idal_pkg::id_t'(phase_count[p]));
      n = (phase_count[p] == 0) ? 1 : ((phase_count[p] > POOL) ? POOL : phase_count[p]);
      push_cmd(idal_pkg::CMD_REINIT, $urandom);
      gen_phase((n >= POOL) ? 50 : 95, phase_base[p], n);
      settings_seen++;
    end

    // last part runs without idling on either side
    wait_quiet();
    idle_pct = 0;
    stall_pct = 0;
    write_reg(idal_pkg::CFG_BASE_ID, $urandom);
    write_reg(idal_pkg::CFG_ID_COUNT, 32'd12);
    push_cmd(idal_pkg::CMD_REINIT, $urandom);
    gen_phase(150, shadow_base, 12);
    settings_seen++;

    wait_quiet();
    repeat (40) @(posedge clk);
    $display("run: %0d items sent, %0d result items checked, %0d pool settings",
             sent_count, recv_count, settings_seen);
    $display("run: %0d allocates on an empty pool, %0d reserves found on the free list",
             empty_allocs, reserve_hits);
    if (fail_count == 0) begin
      $display("tb_id_allocator_free_list_core passed");
    end else begin
      $display("tb_id_allocator_free_list_core failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/idal_pkg.sv
src/idal_ram.sv
src/idal_ctrl.sv
src/id_allocator_free_list_core.sv
tb/sv/tb_id_allocator_free_list_core.sv
